// ===== rtl/core/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared widths, types and the angle table of the coil phase difference
// combiner.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int ACC_BITS     = 40;
    localparam int PROD_BITS    = 2 * SAMPLE_BITS;
    localparam int WIDE_BITS    = ACC_BITS + 2;
    localparam int WORK_BITS    = 56;
    localparam int ANGLE_BITS   = 34;
    localparam int PHASE_BITS   = 16;
    localparam int ROOT_BITS    = 19;
    localparam int HALF_BITS    = ACC_BITS / 2;
    localparam int MAG_BITS     = 2 * ACC_BITS;
    localparam int REM_BITS     = ACC_BITS + 2;
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_STEPS   = ACC_BITS;
    localparam int SQ_STEPS     = 12;
    localparam int CNT_BITS     = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;
    localparam int QCNT_BITS    = QUEUE_AW + 1;

    typedef logic signed [ACC_BITS-1:0] t_acc;

    typedef struct packed {
        t_acc re;
        t_acc im;
    } t_sums;

    typedef struct packed {
        logic                 not_empty;
        logic [QCNT_BITS-1:0] count;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FOLD,
        BK_NORM,
        BK_ROT,
        BK_SQ,
        BK_ROOT,
        BK_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        SH_HIGH,
        SH_CROSS,
        SH_LOW
    } t_sq_shift;

    function automatic t_acc sat_acc(input logic signed [WIDE_BITS-1:0] v);
        t_acc r;
        if ((v[WIDE_BITS-1:ACC_BITS-1] == '0) || (v[WIDE_BITS-1:ACC_BITS-1] == '1)) begin
            r = v[ACC_BITS-1:0];
        end else if (v[WIDE_BITS-1]) begin
            r = {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] atan_unit(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// ===== rtl/core/cpd_item_if.sv =====
// ----------------------------------------------------------------------------
// cpd_item_if
// Input channel: one coil's first-echo and second-echo samples per item.
// ----------------------------------------------------------------------------
interface cpd_item_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_echo_real;
    logic signed [15:0] first_echo_imag;
    logic signed [15:0] second_echo_real;
    logic signed [15:0] second_echo_imag;
    logic               last_coil;

    modport source (
        output valid, first_echo_real, first_echo_imag,
        output second_echo_real, second_echo_imag, last_coil,
        input  ready
    );
    modport sink (
        input  valid, first_echo_real, first_echo_imag,
        input  second_echo_real, second_echo_imag, last_coil,
        output ready
    );
endinterface

// ===== rtl/core/cpd_result_if.sv =====
// ----------------------------------------------------------------------------
// cpd_result_if
// Result channel: wrapped phase and root magnitude of one voxel per item.
// ----------------------------------------------------------------------------
interface cpd_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wrapped_phase;
    logic [18:0]        root_magnitude;

    modport source (
        output valid, wrapped_phase, root_magnitude,
        input  ready
    );
    modport sink (
        input  valid, wrapped_phase, root_magnitude,
        output ready
    );
endinterface

// ===== rtl/core/cpd_queue.sv =====
// ----------------------------------------------------------------------------
// cpd_queue
// Short queue of finished voxel sums between the accumulator and the back end.
// ----------------------------------------------------------------------------
module cpd_queue
    import cpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_sums     i_push_data,
    input  logic      i_pop,
    output t_sums     o_pop_data,
    output t_q_status o_status
);

    t_sums                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp;
    logic [QUEUE_AW-1:0]  r_rp;
    logic [QCNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_pop_data       = r_mem[r_rp];
    assign o_status.count     = r_count;
    assign o_status.not_empty = (r_count != '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_BITS'(QUEUE_DEPTH)))
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("Queue read while empty.");
`endif

endmodule

// ===== rtl/core/cpd_front.sv =====
// ----------------------------------------------------------------------------
// cpd_front
// Takes coil items, forms echo1 times conjugate of echo2 and accumulates it
// with saturation; a voxel's sum goes to the queue on its last coil.
// ----------------------------------------------------------------------------
module cpd_front
    import cpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpd_item_if.sink  i_item,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_sums     o_push_data
);

    logic                        r_v1;
    logic                        r_last1;
    logic signed [PROD_BITS-1:0] r_p_rr;
    logic signed [PROD_BITS-1:0] r_p_ii;
    logic signed [PROD_BITS-1:0] r_p_ir;
    logic signed [PROD_BITS-1:0] r_p_ri;
    t_acc                        r_sum_re;
    t_acc                        r_sum_im;

    logic [QCNT_BITS:0]          w_pending;
    logic                        w_accept;
    logic signed [WIDE_BITS-1:0] w_re;
    logic signed [WIDE_BITS-1:0] w_im;
    t_acc                        w_sat_re;
    t_acc                        w_sat_im;

    assign w_pending = {1'b0, i_q_status.count} + (QCNT_BITS+1)'(r_v1 & r_last1);
    assign i_item.ready = (w_pending < (QCNT_BITS+1)'(QUEUE_DEPTH));
    assign w_accept = i_item.valid & i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last1 <= i_item.last_coil;
            r_p_rr  <= i_item.first_echo_real * i_item.second_echo_real;
            r_p_ii  <= i_item.first_echo_imag * i_item.second_echo_imag;
            r_p_ir  <= i_item.first_echo_imag * i_item.second_echo_real;
            r_p_ri  <= i_item.first_echo_real * i_item.second_echo_imag;
        end
    end

    assign w_re = WIDE_BITS'(r_sum_re) + WIDE_BITS'(r_p_rr) + WIDE_BITS'(r_p_ii);
    assign w_im = WIDE_BITS'(r_sum_im) + WIDE_BITS'(r_p_ir) - WIDE_BITS'(r_p_ri);
    assign w_sat_re = sat_acc(w_re);
    assign w_sat_im = sat_acc(w_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_re <= '0;
            r_sum_im <= '0;
        end else if (r_v1) begin
            r_sum_re <= r_last1 ? '0 : w_sat_re;
            r_sum_im <= r_last1 ? '0 : w_sat_im;
        end
    end

    assign o_push         = r_v1 & r_last1;
    assign o_push_data.re = w_sat_re;
    assign o_push_data.im = w_sat_im;

`ifndef SYNTHESIS
    a_last_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.last_coil) |=> o_push)
        else $error("Last coil item did not push its sum.");
`endif

endmodule

// ===== rtl/core/cpd_back.sv =====
// ----------------------------------------------------------------------------
// cpd_back
// Per voxel sum: CORDIC phase with pre-normalization, then the fourth root
// of the squared magnitude as two passes of a bit-pair square root.
// ----------------------------------------------------------------------------
module cpd_back
    import cpd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_q_status    i_q_status,
    input  t_sums        i_q_data,
    output logic         o_pop,
    cpd_result_if.source o_result
);

    t_back_state                  r_state, n_state;
    logic [CNT_BITS-1:0]          r_cnt, n_cnt;
    logic                         r_pass, n_pass;
    t_acc                         r_re, n_re;
    t_acc                         r_im, n_im;
    logic signed [WORK_BITS-1:0]  r_x, n_x;
    logic signed [WORK_BITS-1:0]  r_y, n_y;
    logic signed [WORK_BITS-1:0]  r_m, n_m;
    logic signed [ANGLE_BITS-1:0] r_z, n_z;
    logic [ACC_BITS-1:0]          r_ar, n_ar;
    logic [ACC_BITS-1:0]          r_ai, n_ai;
    logic [ACC_BITS-1:0]          r_prod, n_prod;
    t_sq_shift                    r_psh, n_psh;
    logic [MAG_BITS-1:0]          r_n, n_n;
    logic [REM_BITS-1:0]          r_rem, n_rem;
    logic [ACC_BITS-1:0]          r_q, n_q;
    logic [ROOT_BITS-1:0]         r_root, n_root;
    logic                         r_out_valid, n_out_valid;
    logic signed [PHASE_BITS-1:0] r_out_phase, n_out_phase;
    logic [ROOT_BITS-1:0]         r_out_root, n_out_root;

    logic signed [WORK_BITS-1:0]  w_fx, w_fy, w_ay, w_dx, w_dy;
    logic signed [ANGLE_BITS-1:0] w_zr;
    logic [HALF_BITS-1:0]         w_hi, w_lo, w_opa, w_opb;
    logic [2:0]                   w_step;
    logic [MAG_BITS-1:0]          w_addend;
    logic [REM_BITS-1:0]          w_rem2, w_t;
    logic [ACC_BITS-1:0]          w_qn;
    logic                         w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_re        <= n_re;
        r_im        <= n_im;
        r_x         <= n_x;
        r_y         <= n_y;
        r_m         <= n_m;
        r_z         <= n_z;
        r_ar        <= n_ar;
        r_ai        <= n_ai;
        r_prod      <= n_prod;
        r_psh       <= n_psh;
        r_n         <= n_n;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_root      <= n_root;
        r_out_phase <= n_out_phase;
        r_out_root  <= n_out_root;
    end

    assign w_fx = r_re[ACC_BITS-1] ? -WORK_BITS'(r_re) : WORK_BITS'(r_re);
    assign w_fy = r_re[ACC_BITS-1] ? -WORK_BITS'(r_im) : WORK_BITS'(r_im);
    assign w_ay = w_fy[WORK_BITS-1] ? -w_fy : w_fy;
    assign w_dx = r_y >>> r_cnt[4:0];
    assign w_dy = r_x >>> r_cnt[4:0];
    assign w_zr = r_z + ANGLE_BITS'(32768);

    assign w_step = r_cnt[3:1];
    assign w_hi   = (w_step < 3'd3) ? r_ar[ACC_BITS-1:HALF_BITS] : r_ai[ACC_BITS-1:HALF_BITS];
    assign w_lo   = (w_step < 3'd3) ? r_ar[HALF_BITS-1:0] : r_ai[HALF_BITS-1:0];

    always_comb begin
        case (r_psh)
            SH_HIGH:  w_addend = MAG_BITS'(r_prod) << (2 * HALF_BITS);
            SH_CROSS: w_addend = MAG_BITS'(r_prod) << (HALF_BITS + 1);
            SH_LOW:   w_addend = MAG_BITS'(r_prod);
            default:  w_addend = '0;
        endcase
    end

    assign w_rem2 = {r_rem[REM_BITS-3:0], r_n[MAG_BITS-1:MAG_BITS-2]};
    assign w_t    = {r_q, 2'b01};
    assign w_ge   = (w_rem2 >= w_t);
    assign w_qn   = {r_q[ACC_BITS-2:0], w_ge};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_re        = r_re;
        n_im        = r_im;
        n_x         = r_x;
        n_y         = r_y;
        n_m         = r_m;
        n_z         = r_z;
        n_ar        = r_ar;
        n_ai        = r_ai;
        n_prod      = r_prod;
        n_psh       = r_psh;
        n_n         = r_n;
        n_rem       = r_rem;
        n_q         = r_q;
        n_root      = r_root;
        n_out_valid = r_out_valid & ~o_result.ready;
        n_out_phase = r_out_phase;
        n_out_root  = r_out_root;
        o_pop       = 1'b0;
        w_opa       = w_hi;
        w_opb       = w_hi;
        case (r_state)
            BK_IDLE: begin
                if (i_q_status.not_empty) begin
                    o_pop   = 1'b1;
                    n_re    = i_q_data.re;
                    n_im    = i_q_data.im;
                    n_state = BK_FOLD;
                end
            end
            BK_FOLD: begin
                n_x   = w_fx;
                n_y   = w_fy;
                n_m   = (w_fx > w_ay) ? w_fx : w_ay;
                n_ar  = r_re[ACC_BITS-1] ? ACC_BITS'(-WIDE_BITS'(r_re)) : r_re;
                n_ai  = r_im[ACC_BITS-1] ? ACC_BITS'(-WIDE_BITS'(r_im)) : r_im;
                n_n   = '0;
                n_cnt = '0;
                if (r_re[ACC_BITS-1]) begin
                    n_z = r_im[ACC_BITS-1] ? -(ANGLE_BITS'(1) <<< 31)
                                           : (ANGLE_BITS'(1) <<< 31);
                end else begin
                    n_z = '0;
                end
                if ((r_re == '0) && (r_im == '0)) begin
                    n_state = BK_SQ;
                end else begin
                    n_state = BK_NORM;
                end
            end
            BK_NORM: begin
                if (r_m[WORK_BITS-1:43] == '0) begin
                    n_x = r_x <<< 8;
                    n_y = r_y <<< 8;
                    n_m = r_m <<< 8;
                end else if (r_m[WORK_BITS-1:50] == '0) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                    n_m = r_m <<< 1;
                end else begin
                    n_cnt   = '0;
                    n_state = BK_ROT;
                end
            end
            BK_ROT: begin
                if (!r_y[WORK_BITS-1]) begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + atan_unit(r_cnt[4:0]);
                end else begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - atan_unit(r_cnt[4:0]);
                end
                if (r_cnt == CNT_BITS'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = BK_SQ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            BK_SQ: begin
                if (!r_cnt[0]) begin
                    case (w_step)
                        3'd0, 3'd3: begin
                            w_opa = w_hi;
                            w_opb = w_hi;
                            n_psh = SH_HIGH;
                        end
                        3'd1, 3'd4: begin
                            w_opa = w_hi;
                            w_opb = w_lo;
                            n_psh = SH_CROSS;
                        end
                        default: begin
                            w_opa = w_lo;
                            w_opb = w_lo;
                            n_psh = SH_LOW;
                        end
                    endcase
                    n_prod = w_opa * w_opb;
                end else begin
                    n_n = r_n + w_addend;
                end
                if (r_cnt == CNT_BITS'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_pass  = 1'b0;
                    n_rem   = '0;
                    n_q     = '0;
                    n_state = BK_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            BK_ROOT: begin
                n_rem = w_ge ? (w_rem2 - w_t) : w_rem2;
                n_q   = w_qn;
                n_n   = r_n << 2;
                if (r_cnt == CNT_BITS'(ROOT_STEPS - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    n_q   = '0;
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_n    = MAG_BITS'(w_qn);
                    end else begin
                        n_root  = (w_qn[ACC_BITS-1:ROOT_BITS] != '0) ? '1
                                                                   : w_qn[ROOT_BITS-1:0];
                        n_state = BK_OUT;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_phase = w_zr[31:16];
                    n_out_root  = r_root;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.wrapped_phase  = r_out_phase;
    assign o_result.root_magnitude = r_out_root;

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == BK_IDLE) && i_q_status.not_empty)
        else $error("Sum taken from the queue while busy.");
    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_ROOT) |-> (r_cnt < CNT_BITS'(ROOT_STEPS)))
        else $error("Square root step count out of range.");
`endif

endmodule

// ===== rtl/core/coil_phase_difference_combine_core.sv =====
// Path: products are registered, then summed into the queue. The back end runs fold,
// normalize, 30 CORDIC steps, 12 squaring, 80 root steps, output; a zero sum skips
// normalize and CORDIC. Throughput: one coil item per cycle while the queue has room;
// one voxel at a time in the single back-end sequencer that serves phase and root in turn.
// Reset: synchronous active low; clears the accumulators, queue and result valid.
// ----------------------------------------------------------------------------
// coil_phase_difference_combine_core
// Multi-coil dual-echo phase difference combiner, top level.
// ----------------------------------------------------------------------------
module coil_phase_difference_combine_core
    import cpd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpd_item_if.sink     i_item,
    cpd_result_if.source o_result
);

    logic      w_push;
    t_sums     w_push_data;
    logic      w_pop;
    t_sums     w_pop_data;
    t_q_status w_q_status;

    cpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    cpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    cpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_q_data   (w_pop_data),
        .o_pop      (w_pop),
        .o_result   (o_result)
    );

endmodule

// ===== bench/cpd_phase_checker.sv =====
// ----------------------------------------------------------------------------
// cpd_phase_checker
// Watches the coil and result channels, accumulates the coil products per
// voxel, predicts the phase and fourth-root magnitude, and compares results.
// ----------------------------------------------------------------------------
module cpd_phase_checker
    import cpd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpd_item_if.sink     i_item,
    cpd_result_if.sink   i_result,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_voxels
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] phase;
        logic [18:0]        root;
    } t_voxel_out;

    t_voxel_out voxel_q[$];
    logic signed [63:0] acc_re;
    logic signed [63:0] acc_im;

    function automatic logic signed [63:0] clamp_acc(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (ACC_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic logic signed [31:0] angle_step(input int i);
        logic [31:0] tbl [0:29];
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
        return $signed(tbl[i]);
    endfunction

    function automatic logic signed [15:0] sum_phase(input logic signed [63:0] re,
                                                     input logic signed [63:0] im);
        logic signed [63:0] x, y, z, m, ay, dx, dy, r;
        x = re;
        y = im;
        z = 0;
        if (x == 0 && y == 0) return 16'sd0;
        if (x < 0) begin
            z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            x = -x;
            y = -y;
        end
        ay = (y < 0) ? -y : y;
        m = (x > ay) ? x : ay;
        while (m < (64'sd1 <<< 50)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + angle_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - angle_step(i);
            end
        end
        r = (z + (64'sd1 <<< 15)) >>> 16;
        return r[15:0];
    endfunction

    function automatic logic [18:0] sum_root(input logic signed [63:0] re,
                                            input logic signed [63:0] im);
        logic [127:0] n, c, q;
        logic [63:0] ar, ai;
        logic [20:0] r;
        ar = (re < 0) ? -re : re;
        ai = (im < 0) ? -im : im;
        n = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            c = 128'(r | (21'd1 << b));
            q = c * c * c * c;
            if (q <= n) r = c[20:0];
        end
        if (r > 21'd524287) r = 21'd524287;
        return r[18:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH voxel %0d %s: got %0d, expected %0d", o_voxels, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = voxel_q.size();

    always @(posedge i_clk) begin
        t_voxel_out e;
        if (!i_rst_n) begin
            acc_re <= 0;
            acc_im <= 0;
            o_fail_count <= 0;
            o_voxels <= 0;
            voxel_q.delete();
        end else begin
            if (i_item.valid && i_item.ready) begin
                logic signed [63:0] nr, ni;
                nr = clamp_acc(acc_re + i_item.first_echo_real * i_item.second_echo_real
                    + i_item.first_echo_imag * i_item.second_echo_imag);
                ni = clamp_acc(acc_im + i_item.first_echo_imag * i_item.second_echo_real
                    - i_item.first_echo_real * i_item.second_echo_imag);
                if (i_item.last_coil) begin
                    e.phase = sum_phase(nr, ni);
                    e.root = sum_root(nr, ni);
                    voxel_q.push_back(e);
                    nr = 0;
                    ni = 0;
                end
                acc_re <= nr;
                acc_im <= ni;
            end
            if (i_result.valid && i_result.ready) begin
                if (voxel_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = voxel_q.pop_front();
                    if (i_result.wrapped_phase !== e.phase)
                        report_mismatch("wrapped_phase", i_result.wrapped_phase, e.phase);
                    if (i_result.root_magnitude !== e.root)
                        report_mismatch("root_magnitude", i_result.root_magnitude, e.root);
                end
                o_voxels <= o_voxels + 1;
            end
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random coil items with random gaps and result stalls
// into the phase difference combiner and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, voxels;
    int   cycles = 0;
    int   sent = 0;
    int   accum_hits = 0;

    cpd_item_if   item_ch();
    cpd_result_if result_ch();

    coil_phase_difference_combine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_result(result_ch.source)
    );

    cpd_phase_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .i_result(result_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending), .o_voxels(voxels)
    );

    always #4 i_clk = ~i_clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        logic stall_mode;
        result_ch.ready = 1'b0;
        stall_mode = 1'b0;
        forever begin
            @(posedge i_clk);
            if (cycles % 3000 == 0) stall_mode <= $urandom_range(0, 1);
            if (!stall_mode) result_ch.ready <= 1'b1;
            else result_ch.ready <= ($urandom_range(0, 99) < 70) ||
                ($urandom_range(0, 99) < 5 && result_ch.ready);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("timeout after %0d cycles", cycles);
            $display("coil_phase_difference_combine_core verification failed");
            $finish;
        end
    end

    task automatic send_coil(input logic signed [15:0] ar, input logic signed [15:0] ai,
                             input logic signed [15:0] br, input logic signed [15:0] bi,
                             input logic last, input bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        if (g > 0) begin
            item_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.first_echo_real <= ar;
        item_ch.first_echo_imag <= ai;
        item_ch.second_echo_real <= br;
        item_ch.second_echo_imag <= bi;
        item_ch.last_coil <= last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic signed [15:0] rnd_sample();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 16'sh8000;
        if (p == 1) return 16'sh7FFF;
        if (p == 2) return $signed(16'($urandom_range(0, 15)) - 16'd8);
        return $signed(16'($urandom));
    endfunction

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int coils;
        logic signed [15:0] mx, mn;
        mx = 16'sh7FFF;
        mn = 16'sh8000;
        item_ch.valid = 1'b0;
        item_ch.first_echo_real = '0;
        item_ch.first_echo_imag = '0;
        item_ch.second_echo_real = '0;
        item_ch.second_echo_imag = '0;
        item_ch.last_coil = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero sum, axes, angle of pi in both half planes, extremes.
        send_coil(0, 0, 0, 0, 1, 0);
        send_coil(100, 0, 100, 0, 1, 0);
        send_coil(-100, 0, 100, 0, 1, 0);
        send_coil(-100, 0, 100, 0, 0, 0);
        send_coil(0, -1, 1, 0, 1, 0);
        send_coil(0, 100, 100, 0, 1, 0);
        send_coil(0, -100, 100, 0, 1, 0);
        send_coil(mn, mn, mn, mn, 1, 0);
        send_coil(mx, mx, mx, mx, 1, 0);
        send_coil(mn, mx, mx, mn, 1, 0);
        send_coil(mx, mn, mn, mx, 1, 0);
        send_coil(1, 1, 1, 1, 1, 0);
        // Large products summed over several coils give a wide root.
        for (int i = 0; i < 12; i++) send_coil(mn, mn, mn, mx, (i == 11), 0);
        drain();
        // Hold off until every voxel result has come back.
        repeat (130) @(posedge i_clk);

        while (sent < 1350) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 3) coils = $urandom_range(300, 600);
            else if (p < 10) coils = $urandom_range(33, 64);
            else coils = $urandom_range(1, 8);
            if (coils > 1350 - sent) coils = 1350 - sent;
            if (coils > 256) accum_hits++;
            for (int c = 0; c < coils; c++) begin
                if (p < 3) send_coil(mn, mn, mn, mx, c == coils - 1, 1);
                else send_coil(rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(),
                               c == coils - 1, $urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 40) == 0) drain();
        end
        drain();
        repeat (300) @(posedge i_clk);
        $display("Run covered %0d coil items and %0d voxel results, %0d saturating voxels.",
                 sent, voxels, accum_hits);
        if (fail_count == 0 && pending == 0)
            $display("coil_phase_difference_combine_core verification clean");
        else
            $display("coil_phase_difference_combine_core verification failed");
        $finish;
    end
endmodule
